// File: src/mcd_pkg.sv
// shared types, constants and the axis gap function of the disk move evaluator
`timescale 1ns / 1ps
`default_nettype none
package mcd_pkg;
  localparam int MAX_DISKS = 1024;
  localparam int IDX_BITS = 10;
  localparam int COORD_BITS = 16;
  localparam int ENERGY_BITS = 43;
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_MOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [2:0] REG_CORE_A = 3'd0;
  localparam logic [2:0] REG_SHELL_A = 3'd4;
  localparam logic [41:0] ENERGY_MAX = {42{1'b1}};

  typedef struct packed {
    logic valid;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [1:0] species;
  } disk_t;

  // minimum-image gap along one axis
  function automatic logic [COORD_BITS-1:0] axis_gap(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS-1:0] t;
    t = (a >= b) ? a - b : b - a;
    if (t[COORD_BITS-1]) t = COORD_BITS'(0) - t;
    return t;
  endfunction
endpackage
`default_nettype wire

// File: src/mcd_isqrt.sv
// multi-cycle integer square root, two result bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module mcd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] value,
  output logic             done,
  output logic [16:0]      root
);
  logic [33:0] rem, rem_next;
  logic [33:0] res, res_next;
  logic [33:0] bits, bits_next;
  logic busy;
  integer j;

  always_comb begin
    rem_next = rem;
    res_next = res;
    bits_next = bits;
    for (j = 0; j < 2; j++) begin
      if (bits_next != 34'd0) begin
        if (rem_next >= res_next + bits_next) begin
          rem_next = rem_next - (res_next + bits_next);
          res_next = (res_next >> 1) + bits_next;
        end else begin
          res_next = res_next >> 1;
        end
        bits_next = bits_next >> 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= {1'b0, value};
        res <= 34'd0;
        bits <= 34'h1_0000_0000;
      end else if (busy) begin
        rem <= rem_next;
        res <= res_next;
        bits <= bits_next;
        if (bits_next == 34'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[16:0];
endmodule
`default_nettype wire

// File: src/mc_disk_move_evaluator_top.sv
// top level of the disk move evaluator: disk table, scan sequencer, result register
`timescale 1ns / 1ps
`default_nettype none
// Use: one beat on the input channel (valid/stall) carries a command: load,
// trial move or energy query. Exactly one result beat follows on the output
// channel. The user must write the registers through the plain write port
// only while idle; the block itself does not enforce it. A load or an unused
// code goes straight from S_IDLE to S_OUT with its result; a move or query of
// an absent slot reads the slot in S_SELF and S_SELF_W and then goes to S_OUT
// with an all-zero result. A move or query scans all 1024 table slots, each
// read from the disk memory in S_SCAN and checked in S_CHECK; a query makes one
// pass, a move up to three (core check, new energy, old energy), and every
// in-range like-species neighbour in an energy pass waits in S_SQRT for the
// square root unit. One item is handled at a time: the next input beat is taken
// only once the result beat has left and the block is back in S_IDLE; the scan
// sets the rate. Reset clears the registers at once and then runs a clearing
// pass over all 1024 slots of the disk memory, during which the input is stalled.
// While the receiver stalls the result is held in the output register and no new item is taken.
module mc_disk_move_evaluator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [9:0]  disk_index,
  input  wire logic [15:0] load_x,
  input  wire logic [15:0] load_y,
  input  wire logic [1:0]  load_species,
  input  wire logic        load_present,
  input  wire logic signed [15:0] step_x,
  input  wire logic signed [15:0] step_y,
  input  wire logic        energy_rule,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic             core_overlap,
  output logic signed [42:0] energy_value,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SELF = 4'd1;
  localparam logic [3:0] S_SELF_W = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;
  localparam logic [3:0] S_CLEAR = 4'd8;
  localparam logic [1:0] P_CORE = 2'd0;
  localparam logic [1:0] P_NEW = 2'd1;
  localparam logic [1:0] P_OLD = 2'd2;

  logic [14:0] core_r [4];
  logic [13:0] shell_r [4];
  mcd_pkg::disk_t mem [mcd_pkg::MAX_DISKS];

  logic [3:0] state;
  logic [1:0] pass;
  logic [1:0] op;
  logic [9:0] k;
  logic rule;
  logic [15:0] sx, sy;
  logic [15:0] px, py, ox, oy, nx, ny;
  logic [1:0] ksp;
  logic [10:0] cnt;
  logic [9:0] rd_idx;
  logic rd_ok;
  mcd_pkg::disk_t rd_data;
  logic [41:0] esum, e_new;
  logic [32:0] d2;
  logic [14:0] two_r;
  logic [15:0] lim;

  logic we;
  logic [9:0] wa;
  mcd_pkg::disk_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core_r <= '{default: '0};
      shell_r <= '{default: '0};
    end else if (cfg_we) begin
      if (cfg_index < mcd_pkg::REG_SHELL_A) core_r[cfg_index[1:0]] <= cfg_data;
      else shell_r[cfg_index[1:0]] <= cfg_data[13:0];
    end
  end

  // squared distance of the slot just read to the probe position
  logic [15:0] gx, gy;
  logic [31:0] gx2, gy2;
  logic [32:0] d2_c;
  always_comb begin
    gx = mcd_pkg::axis_gap(px, rd_data.x);
    gy = mcd_pkg::axis_gap(py, rd_data.y);
    gx2 = gx * gx;
    gy2 = gy * gy;
    d2_c = {1'b0, gx2} + {1'b0, gy2};
  end

  logic [9:0] scan_i;
  logic scan_last;
  assign scan_last = (cnt == 11'(mcd_pkg::MAX_DISKS));
  logic sq_start, sq_done;
  logic [16:0] root;
  mcd_isqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .value(d2), .done(sq_done),
    .root(root));

  logic hit;
  assign hit = rd_ok && rd_data.valid;

  logic [16:0] tdiff;
  logic [33:0] tsq;
  logic [42:0] esum_add;
  assign tdiff = {2'b0, two_r} - root;
  assign tsq = tdiff * tdiff;
  assign esum_add = {1'b0, esum} + {9'b0, tsq};
  logic [31:0] lim_sq;
  logic [31:0] tr_sq;
  assign lim = {1'b0, core_r[ksp]} + {1'b0, core_r[rd_data.species]};
  assign lim_sq = lim * lim;
  assign tr_sq = {1'b0, two_r} * {1'b0, two_r};

  assign in_stall = (state != S_IDLE);
  assign scan_i = cnt[9:0];

  always_comb begin
    we = 1'b0;
    wa = k;
    wd.valid = 1'b1;
    wd.x = nx;
    wd.y = ny;
    wd.species = ksp;
    rd_idx = (state == S_IDLE || state == S_SELF) ? k : scan_i;
    if (state == S_IDLE && in_valid) rd_idx = disk_index;
    if (state == S_DONE && op == mcd_pkg::FUNC_MOVE && pass == P_OLD &&
        !(rule && e_new > esum)) we = 1'b1;
    if (state == S_IDLE && in_valid && func == mcd_pkg::FUNC_LOAD) begin
      we = 1'b1;
      wa = disk_index;
      wd.valid = load_present;
      wd.x = load_x;
      wd.y = load_y;
      wd.species = load_species;
    end
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = scan_i;
      wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      out_valid <= 1'b0;
      sq_start <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 11'd1;
          if (cnt == 11'(mcd_pkg::MAX_DISKS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= func;
            k <= disk_index;
            rule <= energy_rule;
            sx <= step_x;
            sy <= step_y;
            accepted <= 1'b0;
            core_overlap <= 1'b0;
            energy_value <= '0;
            if (func == mcd_pkg::FUNC_LOAD) begin
              accepted <= 1'b1;
              state <= S_OUT;
              out_valid <= 1'b1;
            end else if (func == mcd_pkg::FUNC_MOVE || func == mcd_pkg::FUNC_QUERY) begin
              state <= S_SELF;
            end else begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end
          end
        end
        S_SELF: state <= S_SELF_W;
        S_SELF_W: begin
          ox <= rd_data.x;
          oy <= rd_data.y;
          ksp <= rd_data.species;
          nx <= rd_data.x + sx;
          ny <= rd_data.y + sy;
          two_r <= {shell_r[rd_data.species], 1'b0};
          esum <= '0;
          cnt <= '0;
          if (op == mcd_pkg::FUNC_MOVE) begin
            pass <= P_CORE;
            px <= rd_data.x + sx;
            py <= rd_data.y + sy;
          end else begin
            pass <= P_OLD;
            px <= rd_data.x;
            py <= rd_data.y;
          end
          // absent slot gives an all-zero result
          if (rd_data.valid) begin
            state <= S_SCAN;
          end else begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 11'd1;
          rd_ok <= (scan_i != k);
          state <= S_CHECK;
        end
        S_CHECK: begin
          d2 <= d2_c;
          state <= S_SCAN;
          if (hit && pass == P_CORE) begin
            if (d2_c <= {1'b0, lim_sq}) begin
              core_overlap <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else if (scan_last) state <= S_DONE;
          end else if (hit && rd_data.species == ksp && d2_c < {1'b0, tr_sq}) begin
            sq_start <= 1'b1;
            state <= S_SQRT;
          end else if (scan_last) state <= S_DONE;
        end
        S_SQRT: begin
          if (sq_done) begin
            esum <= esum_add[42] ? mcd_pkg::ENERGY_MAX : esum_add[41:0];
            state <= scan_last ? S_DONE : S_SCAN;
          end
        end
        S_DONE: begin
          cnt <= '0;
          case (pass)
            P_CORE: begin
              pass <= P_NEW;
              esum <= '0;
              state <= S_SCAN;
            end
            P_NEW: begin
              e_new <= esum;
              pass <= P_OLD;
              esum <= '0;
              px <= ox;
              py <= oy;
              state <= S_SCAN;
            end
            default: begin
              if (op == mcd_pkg::FUNC_MOVE) begin
                energy_value <= {1'b0, e_new} - {1'b0, esum};
                accepted <= !(rule && e_new > esum);
              end else begin
                energy_value <= {1'b0, esum};
              end
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/mcd_checker.sv
// port checker of the disk move evaluator and its bind
`timescale 1ns / 1ps
`default_nettype none
module mcd_props (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic accepted,
  input wire logic core_overlap,
  input wire logic [42:0] energy_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(energy_value))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && core_overlap)) else $error("overlap with accept");
  a_ovl: assert property (@(posedge clk) disable iff (rst)
    out_valid && core_overlap |-> energy_value == 43'd0) else $error("overlap energy");
endmodule
bind mc_disk_move_evaluator_top mcd_props u_props (.clk(clk), .rst(rst),
  .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .accepted(accepted), .core_overlap(core_overlap),
  .energy_value(energy_value));
`default_nettype wire

// File: tb/mcd_checker.sv
// checker for the disk move evaluator: watches both channels, predicts results, compares
`timescale 1ns / 1ps
`default_nettype none
module mcd_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [9:0]  disk_index,
  input  wire logic [15:0] load_x,
  input  wire logic [15:0] load_y,
  input  wire logic [1:0]  load_species,
  input  wire logic        load_present,
  input  wire logic [15:0] step_x,
  input  wire logic [15:0] step_y,
  input  wire logic        energy_rule,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        accepted,
  input  wire logic        core_overlap,
  input  wire logic [42:0] energy_value,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               commits,
  output int               contacts
);
  typedef struct {
    logic        acc;
    logic        ovl;
    logic [42:0] energy;
  } verdict_t;

  logic [14:0] core_r [4];
  logic [13:0] shell_r [4];
  logic [15:0] pos_x [mcd_pkg::MAX_DISKS];
  logic [15:0] pos_y [mcd_pkg::MAX_DISKS];
  logic [1:0]  kind [mcd_pkg::MAX_DISKS];
  logic        present [mcd_pkg::MAX_DISKS];
  verdict_t    due_q [$];

  function automatic logic [63:0] wrap_gap(input logic [15:0] a, input logic [15:0] b);
    logic [63:0] t;
    t = (a >= b) ? 64'(a - b) : 64'(b - a);
    if (t >= 64'd32768) t = 64'd65536 - t;
    return t;
  endfunction

  function automatic logic [63:0] gap_sq(input logic [15:0] x1, input logic [15:0] y1,
                                        input logic [15:0] x2, input logic [15:0] y2);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = wrap_gap(x1, x2);
    dy = wrap_gap(y1, y2);
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic hits_core(input int k, input logic [15:0] px, input logic [15:0] py);
    logic [63:0] lim;
    for (int i = 0; i < mcd_pkg::MAX_DISKS; i++) begin
      if (i != k && present[i]) begin
        lim = 64'(core_r[kind[k]]) + 64'(core_r[kind[i]]);
        if (gap_sq(px, py, pos_x[i], pos_y[i]) <= lim * lim) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [63:0] shell_sum(input int k, input logic [15:0] px,
                                           input logic [15:0] py);
    logic [63:0] two_r;
    logic [63:0] d2;
    logic [63:0] t;
    logic [63:0] e;
    two_r = 64'(shell_r[kind[k]]) * 2;
    e = 0;
    for (int i = 0; i < mcd_pkg::MAX_DISKS; i++) begin
      if (i != k && present[i] && kind[i] == kind[k]) begin
        d2 = gap_sq(px, py, pos_x[i], pos_y[i]);
        if (d2 < two_r * two_r) begin
          t = two_r - floor_root(d2);
          e += t * t;
          if (e > 64'(mcd_pkg::ENERGY_MAX)) e = 64'(mcd_pkg::ENERGY_MAX);
        end
      end
    end
    return e;
  endfunction

  function automatic verdict_t evaluate_beat();
    verdict_t v;
    int k;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [63:0] e_new;
    logic [63:0] e_old;
    v = '{1'b0, 1'b0, 43'd0};
    k = int'(disk_index);
    case (func)
      mcd_pkg::FUNC_LOAD: begin
        if (load_present) begin
          pos_x[k] = load_x;
          pos_y[k] = load_y;
          kind[k] = load_species;
          present[k] = 1'b1;
        end else begin
          present[k] = 1'b0;
        end
        v.acc = 1'b1;
      end
      mcd_pkg::FUNC_MOVE: begin
        if (present[k]) begin
          nx = pos_x[k] + step_x;
          ny = pos_y[k] + step_y;
          if (hits_core(k, nx, ny)) begin
            v.ovl = 1'b1;
            contacts++;
          end else begin
            e_new = shell_sum(k, nx, ny);
            e_old = shell_sum(k, pos_x[k], pos_y[k]);
            v.energy = 43'(e_new - e_old);
            if (!(energy_rule && e_new > e_old)) begin
              pos_x[k] = nx;
              pos_y[k] = ny;
              v.acc = 1'b1;
              commits++;
            end
          end
        end
      end
      mcd_pkg::FUNC_QUERY: begin
        if (present[k]) v.energy = 43'(shell_sum(k, pos_x[k], pos_y[k]));
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    int bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < mcd_pkg::MAX_DISKS; i++) present[i] = 1'b0;
      for (int i = 0; i < 4; i++) begin
        core_r[i] = '0;
        shell_r[i] = '0;
      end
      due_q.delete();
      errors <= 0;
      commits = 0;
      contacts = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < mcd_pkg::REG_SHELL_A) core_r[cfg_index[1:0]] = cfg_data;
        else shell_r[cfg_index[1:0]] = cfg_data[13:0];
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("result beat with nothing expected");
          bad++;
        end else begin
          want = due_q.pop_front();
          if (accepted !== want.acc) begin
            $error("accepted: expected %0d got %0d", want.acc, accepted);
            bad++;
          end
          if (core_overlap !== want.ovl) begin
            $error("core_overlap: expected %0d got %0d", want.ovl, core_overlap);
            bad++;
          end
          if (energy_value !== want.energy) begin
            $error("energy_value: expected %0d got %0d",
                   $signed(want.energy), $signed(energy_value));
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) due_q.push_back(evaluate_beat());
      errors <= errors + bad;
    end
    pending <= due_q.size();
  end
endmodule
`default_nettype wire

// File: tb/tb_mc_disk_move_evaluator_top.sv
// testbench top for the disk move evaluator: clock, reset, stimulus, verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_mc_disk_move_evaluator_top;
  import mcd_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 6000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_LOAD;
  logic [9:0] disk_index = '0;
  logic [15:0] load_x = '0;
  logic [15:0] load_y = '0;
  logic [1:0] load_species = '0;
  logic load_present = 1'b0;
  logic signed [15:0] step_x = '0;
  logic signed [15:0] step_y = '0;
  logic energy_rule = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic accepted;
  logic core_overlap;
  logic signed [42:0] energy_value;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;

  int errors;
  int pending;
  int commits;
  int contacts;
  int beats_in = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int idle_count = 0;
  int burst_left = 0;
  logic [9:0] slot_pool [48];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mc_disk_move_evaluator_top dut (.*);

  mcd_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .disk_index(disk_index), .load_x(load_x), .load_y(load_y),
    .load_species(load_species), .load_present(load_present), .step_x(step_x),
    .step_y(step_y), .energy_rule(energy_rule), .out_valid(out_valid),
    .out_stall(out_stall), .accepted(accepted), .core_overlap(core_overlap),
    .energy_value(energy_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending), .commits(commits),
    .contacts(contacts)
  );

  // receiver: random stall pattern, quiet stretches, and requested long hold-offs
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if ($urandom_range(0, 399) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_mode == 1) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else if (stall_mode == 2) begin
      out_stall <= ($urandom_range(0, 1) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > IDLE_LIMIT) begin
      $display("tb_mc_disk_move_evaluator_top: done, errors");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] f, input logic [9:0] idx,
                           input logic [15:0] lx, input logic [15:0] ly,
                           input logic [1:0] sp, input logic pr,
                           input logic [15:0] sx, input logic [15:0] sy,
                           input logic er);
    func <= f;
    disk_index <= idx;
    load_x <= lx;
    load_y <= ly;
    load_species <= sp;
    load_present <= pr;
    step_x <= sx;
    step_y <= sy;
    energy_rule <= er;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || out_valid) @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0][14:0] core, input logic [3:0][13:0] shell);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= (i < 4) ? core[i] : 15'(shell[i-4]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_beat();
    int r;
    logic [15:0] sx;
    logic [15:0] sy;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) begin
      sx = 16'($signed($urandom_range(0, 4000)) - 2000);
      sy = 16'($signed($urandom_range(0, 4000)) - 2000);
    end else begin
      sx = 16'($urandom);
      sy = 16'($urandom);
    end
    if (r < 35)
      send_beat(FUNC_LOAD, slot_pool[$urandom_range(0, 47)], 16'($urandom), 16'($urandom),
                2'($urandom), $urandom_range(0, 5) != 0, 16'($urandom), 16'($urandom),
                1'($urandom));
    else if (r < 75)
      send_beat(FUNC_MOVE, slot_pool[$urandom_range(0, 47)], 16'($urandom), 16'($urandom),
                2'($urandom), 1'($urandom), sx, sy, 1'($urandom));
    else if (r < 95)
      send_beat(FUNC_QUERY, slot_pool[$urandom_range(0, 47)], 16'($urandom), 16'($urandom),
                2'($urandom), 1'($urandom), sx, sy, 1'($urandom));
    else
      send_beat(2'd3, 10'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                1'($urandom), sx, sy, 1'($urandom));
  endtask

  initial begin
    slot_pool[0] = 10'd0;
    slot_pool[1] = 10'd1023;
    for (int b = 0; b < 10; b++) begin
      slot_pool[2 + b] = 10'(1 << b);
      slot_pool[12 + b] = 10'd1023 ^ 10'(1 << b);
    end
    for (int i = 22; i < 48; i++) slot_pool[i] = 10'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_regs({15'd1600, 15'd800, 15'd400, 15'd200},
                 {14'd16383, 14'd3000, 14'd2000, 14'd1000});
    // touching cores, wrap across the box corner, removal, unused code, absent slots
    send_beat(FUNC_LOAD, 10'd0, 16'd0, 16'd0, 2'd0, 1'b1, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_LOAD, 10'd1023, 16'hFFFF, 16'hFFFF, 2'd0, 1'b1, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_MOVE, 10'd0, 16'd0, 16'd0, 2'd0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_LOAD, 10'd1023, 16'd0, 16'd0, 2'd0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_LOAD, 10'd512, 16'd400, 16'd0, 2'd0, 1'b1, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_MOVE, 10'd0, 16'd0, 16'd0, 2'd0, 1'b0, 16'd0, 16'd0, 1'b1);
    send_beat(FUNC_MOVE, 10'd0, 16'd0, 16'd0, 2'd0, 1'b0, 16'hFFFF, 16'd0, 1'b1);
    send_beat(FUNC_QUERY, 10'd0, 16'd0, 16'd0, 2'd0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_QUERY, 10'd512, 16'd0, 16'd0, 2'd0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_MOVE, 10'd700, 16'd0, 16'd0, 2'd0, 1'b0, 16'd5, 16'd5, 1'b0);
    send_beat(FUNC_QUERY, 10'd700, 16'd0, 16'd0, 2'd0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_beat(2'd3, 10'd0, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_beat(FUNC_LOAD, 10'd5, 16'd32768, 16'd32768, 2'd3, 1'b1, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_MOVE, 10'd5, 16'd0, 16'd0, 2'd0, 1'b0, 16'h8000, 16'h7FFF, 1'b0);
    send_beat(FUNC_MOVE, 10'd5, 16'd0, 16'd0, 2'd0, 1'b0, 16'h7FFF, 16'h8000, 1'b1);
    send_beat(FUNC_LOAD, 10'd6, 16'd33000, 16'd33000, 2'd3, 1'b1, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_MOVE, 10'd6, 16'd0, 16'd0, 2'd0, 1'b0, 16'd100, 16'd100, 1'b1);
    send_beat(FUNC_MOVE, 10'd6, 16'd0, 16'd0, 2'd0, 1'b0, -16'sd3000, -16'sd3000, 1'b1);
    send_beat(FUNC_QUERY, 10'd6, 16'd0, 16'd0, 2'd0, 1'b0, 16'd0, 16'd0, 1'b0);
    send_beat(FUNC_LOAD, 10'd700, 16'd0, 16'd0, 2'd1, 1'b0, 16'd0, 16'd0, 1'b0);

    for (int i = 0; i < 100; i++) begin
      if (i == 40) hold_asks++;
      if (i == 70) drain();
      random_beat();
    end
    program_regs({4{15'd0}}, {4{14'd16383}});
    for (int i = 0; i < 60; i++) random_beat();
    program_regs({4{15'd32767}}, {4{14'd0}});
    for (int i = 0; i < 40; i++) random_beat();
    program_regs({15'($urandom_range(0, 3000)), 15'($urandom_range(0, 3000)),
                  15'($urandom_range(0, 3000)), 15'($urandom_range(0, 3000))},
                 {14'($urandom_range(0, 8000)), 14'($urandom_range(0, 8000)),
                  14'($urandom_range(0, 8000)), 14'($urandom_range(0, 8000))});
    for (int i = 0; i < 80; i++) random_beat();

    drain();
    repeat (50) @(posedge clk);
    $display("run covered %0d command beats over four register settings", beats_in);
    $display("moves committed %0d, moves stopped by core contact %0d", commits, contacts);
    if (errors == 0) begin
      $display("tb_mc_disk_move_evaluator_top: done, clean");
    end else begin
      $display("tb_mc_disk_move_evaluator_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
